@@ sv/c2d_pkg.sv @@
// ----------------------------------------------------------------------------
// c2d_pkg: shared constants and types for the 3x3 streaming convolution
// Sizes of the sample path, coefficient layout, register indexes and the
// line memory word and write-port bundle.
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS    = COL_BITS + 1;
  localparam int HEIGHT_BITS   = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int TAPS          = 3;
  localparam int COEF_ROW_BITS = TAPS * COEF_BITS;
  localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
  localparam int ROW_SUM_BITS  = PROD_BITS + 2;
  localparam int SUM_BITS      = 35;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = WIDTH_BITS'(TAPS);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = HEIGHT_BITS'(TAPS);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(500);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(500);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_TOP = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_MID = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_BOT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [COEF_BITS-1:0]    coef_t;
  typedef logic signed [PROD_BITS-1:0]    prod_t;
  typedef logic signed [ROW_SUM_BITS-1:0] row_sum_t;
  typedef logic signed [SUM_BITS-1:0]     sum_t;
  typedef logic [COL_BITS-1:0]            col_t;

  // one line memory entry: column sample of row r-2 and of row r-1
  typedef struct packed {
    sample_t older;
    sample_t newer;
  } line_word_t;

  typedef struct packed {
    logic       en;
    col_t       addr;
    line_word_t data;
  } line_wr_t;

endpackage

@@ sv/conv2d_3x3_stream.sv @@
// ----------------------------------------------------------------------------
// conv2d_3x3_stream: streaming 3x3 weighted sum over the valid image region
// Pipeline: the sample beat passes stage 1, products, row sums and the output register.
// Throughput: one sample per cycle while in_stall is low, set by the single line memory read per beat.
// Reset: counters, window and pipeline clear; coefficients 0, geometry 500x500.
// After reset a pass zeroes all 1024 line memory entries with in_stall high;
// configuration writes are taken throughout (cfg_ready is always high).
// ----------------------------------------------------------------------------
module conv2d_3x3_stream (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // sample input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [c2d_pkg::SAMPLE_BITS-1:0] in_sample,
  // result output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [c2d_pkg::SUM_BITS-1:0]    out_weighted_sum,
  output logic [c2d_pkg::HEIGHT_BITS-1:0]        out_centre_row,
  output logic [c2d_pkg::COL_BITS-1:0]           out_centre_col,
  output logic                                   out_frame_last,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [c2d_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [c2d_pkg::COEF_ROW_BITS-1:0]      cfg_data
);

  localparam int TAPS = c2d_pkg::TAPS;

  // configuration
  logic [c2d_pkg::COEF_ROW_BITS-1:0] coef_r [TAPS];
  logic [c2d_pkg::WIDTH_BITS-1:0]    width_r;
  logic [c2d_pkg::HEIGHT_BITS-1:0]   height_r;

  // clearing pass
  logic          clr_busy_r;
  c2d_pkg::col_t clr_addr_r;

  // counters
  c2d_pkg::col_t                   col_r, col_nxt;
  logic [c2d_pkg::HEIGHT_BITS-1:0] row_r, row_nxt;

  // stage 1: sample waiting for its line memory read
  logic                            p1_valid_r;
  logic                            p1_emit_r;
  logic                            p1_last_r;
  c2d_pkg::sample_t                p1_sample_r;
  c2d_pkg::col_t                   p1_col_r;
  logic [c2d_pkg::HEIGHT_BITS-1:0] p1_crow_r;
  c2d_pkg::col_t                   p1_ccol_r;

  // stage 2: products
  logic                            p2_valid_r;
  logic                            p2_last_r;
  logic [c2d_pkg::HEIGHT_BITS-1:0] p2_crow_r;
  c2d_pkg::col_t                   p2_ccol_r;
  c2d_pkg::prod_t                  prod_r [TAPS][TAPS];
  c2d_pkg::prod_t                  prod_nxt [TAPS][TAPS];

  // stage 3: row sums
  logic                            p3_valid_r;
  logic                            p3_last_r;
  logic [c2d_pkg::HEIGHT_BITS-1:0] p3_crow_r;
  c2d_pkg::col_t                   p3_ccol_r;
  c2d_pkg::row_sum_t               rsum_r [TAPS];

  // output register
  logic                            out_valid_r;
  c2d_pkg::sum_t                   out_sum_r;
  logic [c2d_pkg::HEIGHT_BITS-1:0] out_crow_r;
  c2d_pkg::col_t                   out_ccol_r;
  logic                            out_last_r;

  // window
  c2d_pkg::sample_t taps_r   [TAPS][TAPS];
  c2d_pkg::sample_t taps_nxt [TAPS][TAPS];

  // line memory
  c2d_pkg::line_wr_t   mem_wr;
  c2d_pkg::line_word_t mem_rd_data;

  logic out_ld, p3_mv, p2_mv, p1_mv, p1_fire, accept;
  logic [c2d_pkg::WIDTH_BITS-1:0]  w_eff;
  logic [c2d_pkg::HEIGHT_BITS-1:0] h_eff;
  logic [c2d_pkg::WIDTH_BITS-1:0]  col_inc;
  logic [c2d_pkg::HEIGHT_BITS:0]   row_inc;
  logic                            col_wrap, row_wrap;

  // pipeline moves where the next stage has room
  assign out_ld  = !out_valid_r || !out_stall;
  assign p3_mv   = !p3_valid_r || out_ld;
  assign p2_mv   = !p2_valid_r || p3_mv;
  assign p1_mv   = !p1_valid_r || !p1_emit_r || p2_mv;
  assign p1_fire = p1_valid_r && p1_mv;

  assign in_stall  = clr_busy_r || !p1_mv;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < TAPS; m++) begin
        coef_r[m] <= '0;
      end
      width_r  <= c2d_pkg::WIDTH_RESET;
      height_r <= c2d_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        c2d_pkg::CFG_COEF_TOP: coef_r[0] <= cfg_data;
        c2d_pkg::CFG_COEF_MID: coef_r[1] <= cfg_data;
        c2d_pkg::CFG_COEF_BOT: coef_r[2] <= cfg_data;
        c2d_pkg::CFG_WIDTH:    width_r   <= cfg_data[c2d_pkg::WIDTH_BITS-1:0];
        c2d_pkg::CFG_HEIGHT:   height_r  <= cfg_data[c2d_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- geometry
  always_comb begin
    if (width_r < c2d_pkg::WIDTH_MIN) begin
      w_eff = c2d_pkg::WIDTH_MIN;
    end else if (width_r > c2d_pkg::WIDTH_MAX) begin
      w_eff = c2d_pkg::WIDTH_MAX;
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r < c2d_pkg::HEIGHT_MIN) ? c2d_pkg::HEIGHT_MIN : height_r;

    col_inc  = {1'b0, col_r} + c2d_pkg::WIDTH_BITS'(1);
    row_inc  = {1'b0, row_r} + (c2d_pkg::HEIGHT_BITS + 1)'(1);
    col_wrap = col_inc >= w_eff;
    row_wrap = row_inc >= {1'b0, h_eff};

    col_nxt = col_wrap ? '0 : col_inc[c2d_pkg::COL_BITS-1:0];
    if (col_wrap) begin
      row_nxt = row_wrap ? '0 : row_inc[c2d_pkg::HEIGHT_BITS-1:0];
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------- clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + c2d_pkg::COL_BITS'(1);
      if (clr_addr_r == c2d_pkg::COL_BITS'(c2d_pkg::MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------- line memory
  // stage 1 writes back the column it read; consecutive beats never share
  // a column, so no forwarding is needed
  always_comb begin
    if (clr_busy_r) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clr_addr_r;
      mem_wr.data = '0;
    end else begin
      mem_wr.en         = p1_fire;
      mem_wr.addr       = p1_col_r;
      mem_wr.data.older = mem_rd_data.newer;
      mem_wr.data.newer = p1_sample_r;
    end
  end

  c2d_line_mem u_line_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (mem_rd_data)
  );

  // --------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (p1_mv) begin
      p1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_sample_r <= in_sample;
      p1_col_r    <= col_r;
      p1_emit_r   <= (row_r >= c2d_pkg::HEIGHT_BITS'(2)) && (col_r >= c2d_pkg::COL_BITS'(2));
      p1_last_r   <= col_wrap && row_wrap;
      p1_crow_r   <= row_r - c2d_pkg::HEIGHT_BITS'(1);
      p1_ccol_r   <= col_r - c2d_pkg::COL_BITS'(1);
    end
  end

  // window shift and products
  always_comb begin
    for (int m = 0; m < TAPS; m++) begin
      taps_nxt[m][0] = taps_r[m][1];
      taps_nxt[m][1] = taps_r[m][2];
    end
    taps_nxt[0][2] = mem_rd_data.older;
    taps_nxt[1][2] = mem_rd_data.newer;
    taps_nxt[2][2] = p1_sample_r;

    for (int m = 0; m < TAPS; m++) begin
      for (int n = 0; n < TAPS; n++) begin
        prod_nxt[m][n] =
          c2d_pkg::PROD_BITS'(c2d_pkg::coef_t'(coef_r[m][n*c2d_pkg::COEF_BITS +: c2d_pkg::COEF_BITS]))
          * c2d_pkg::PROD_BITS'(taps_nxt[m][n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < TAPS; m++) begin
        for (int n = 0; n < TAPS; n++) begin
          taps_r[m][n] <= '0;
        end
      end
    end else if (p1_fire) begin
      taps_r <= taps_nxt;
    end
  end

  // --------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (p2_mv) begin
      p2_valid_r <= p1_valid_r && p1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_fire && p1_emit_r) begin
      prod_r    <= prod_nxt;
      p2_last_r <= p1_last_r;
      p2_crow_r <= p1_crow_r;
      p2_ccol_r <= p1_ccol_r;
    end
  end

  // --------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (p3_mv) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_mv && p2_valid_r) begin
      for (int m = 0; m < TAPS; m++) begin
        rsum_r[m] <= c2d_pkg::ROW_SUM_BITS'(prod_r[m][0])
                   + c2d_pkg::ROW_SUM_BITS'(prod_r[m][1])
                   + c2d_pkg::ROW_SUM_BITS'(prod_r[m][2]);
      end
      p3_last_r <= p2_last_r;
      p3_crow_r <= p2_crow_r;
      p3_ccol_r <= p2_ccol_r;
    end
  end

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && p3_valid_r) begin
      out_sum_r  <= c2d_pkg::SUM_BITS'(rsum_r[0])
                  + c2d_pkg::SUM_BITS'(rsum_r[1])
                  + c2d_pkg::SUM_BITS'(rsum_r[2]);
      out_last_r <= p3_last_r;
      out_crow_r <= p3_crow_r;
      out_ccol_r <= p3_ccol_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_weighted_sum = out_sum_r;
  assign out_centre_row   = out_crow_r;
  assign out_centre_col   = out_ccol_r;
  assign out_frame_last   = out_last_r;

endmodule

@@ sv/c2d_line_mem.sv @@
// ----------------------------------------------------------------------------
// c2d_line_mem: line buffer memory
// One entry per image column holding the two previous rows. One write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module c2d_line_mem (
  input  logic                clk,
  input  c2d_pkg::line_wr_t   wr,
  input  logic                rd_en,
  input  c2d_pkg::col_t       rd_addr,
  output c2d_pkg::line_word_t rd_data
);

  c2d_pkg::line_word_t mem [c2d_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
